// ===== rtl/spi_ee_pkg.sv =====
package spi_ee_pkg;

   // Default memory size in bytes
   localparam int MEM_BYTES_DEFAULT = 4096;

   // Command and response bytes
   localparam logic [7:0] CMD_WRITE      = 8'h02;
   localparam logic [7:0] CMD_READ       = 8'h03;
   localparam logic [7:0] RESP_READ_CMD  = 8'hA5;
   localparam logic [7:0] RESP_ADDR_HIGH = 8'hA6;
   localparam logic [7:0] RESP_IDLE      = 8'hFF;
   localparam logic [7:0] RESP_ZERO      = 8'h00;
   localparam logic [7:0] ERASED_BYTE    = 8'hFF;

   // Default image layout
   localparam int IMAGE_BYTES = 512;
   localparam int HEAD_BYTES  = 224;
   localparam int TAIL_START  = 476;
   localparam int TAIL_BYTES  = 36;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_SEL_ON  = 2'd1,
      OP_SEL_OFF = 2'd2,
      OP_DIRECT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_COMMAND   = 3'd0,
      PH_ADDR_HIGH = 3'd1,
      PH_ADDR_LOW  = 3'd2,
      PH_WRITE     = 3'd3,
      PH_READ      = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_WRITE = 2'd1,
      PEND_READ  = 2'd2
   } pend_type;

   // Memory access issued by the SPI machine
   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic [7:0] wr_data;
   } mem_req_type;

   // Result handed to the output stage
   typedef struct packed {
      logic       valid;
      logic       use_mem;
      logic [7:0] tx_byte;
   } rsp_push_type;

   localparam logic [7:0] IMAGE_HEAD [HEAD_BYTES] = '{
      8'h50, 8'h97, 8'h5C, 8'hEF, 8'hC1, 8'h8F, 8'h05, 8'h8B,
      8'h0E, 8'h8D, 8'hD8, 8'hF5, 8'hAE, 8'h89, 8'hB8, 8'h09,
      8'h0D, 8'h8A, 8'hC9, 8'h0A, 8'h48, 8'h84, 8'h00, 8'h00,
      8'h1A, 8'h97, 8'hAD, 8'h40, 8'hED, 8'h91, 8'hC9, 8'hBE,
      8'hD2, 8'h8B, 8'hBA, 8'h1A, 8'h5E, 8'h87, 8'h4D, 8'h03,
      8'h4F, 8'h8A, 8'hE1, 8'h9C, 8'h48, 8'h84, 8'h00, 8'h00,
      8'h60, 8'h9D, 8'h00, 8'hCC, 8'hAA, 8'h9A, 8'hCD, 8'h3A,
      8'h70, 8'h93, 8'hD5, 8'h66, 8'h31, 8'h94, 8'hA3, 8'hA7,
      8'h30, 8'h97, 8'h4A, 8'h56, 8'hE8, 8'h98, 8'hD0, 8'h43,
      8'h2F, 8'h97, 8'h16, 8'h6A, 8'h50, 8'h93, 8'hFB, 8'h12,
      8'h61, 8'h93, 8'h11, 8'h30, 8'h7F, 8'h96, 8'hB5, 8'hED,
      8'h5D, 8'h75, 8'h4C, 8'hF7, 8'hB1, 8'h76, 8'h37, 8'h3E,
      8'hD1, 8'h78, 8'h48, 8'h16, 8'h00, 8'h80, 8'hA7, 8'hE1,
      8'h64, 8'h4B, 8'h2E, 8'hF9, 8'hA5, 8'h7E, 8'hD3, 8'h8B,
      8'hED, 8'h7A, 8'h43, 8'hC5, 8'h39, 8'h79, 8'h32, 8'h04,
      8'h7F, 8'h7F, 8'h9F, 8'hFE, 8'h25, 8'h7E, 8'hD3, 8'h8B,
      8'h6D, 8'h7A, 8'h43, 8'hC5, 8'hB9, 8'h79, 8'h32, 8'h04,
      8'h30, 8'h70, 8'h77, 8'hB1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h83, 8'h75, 8'hAD, 8'h37,
      8'h0A, 8'h8D, 8'h42, 8'h25, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h2F, 8'h89, 8'h00, 8'h00, 8'hAF, 8'h89, 8'h00, 8'h00,
      8'h06, 8'h00, 8'h18, 8'hA1, 8'h60, 8'h0C, 8'h3A, 8'h7F,
      8'h35, 8'h5E, 8'hBA, 8'h7F, 8'h35, 8'h5E, 8'h18, 8'h79,
      8'hB1, 8'hC3, 8'h02, 8'h00, 8'h06, 8'hFF, 8'h08, 8'h8A,
      8'h00, 8'h80, 8'h88, 8'h8A, 8'h00, 8'h80, 8'h16, 8'h86,
      8'h00, 8'h00, 8'hC8, 8'h84, 8'h00, 8'h00, 8'h50, 8'h95,
      8'hE7, 8'h86, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   localparam logic [7:0] IMAGE_TAIL [TAIL_BYTES] = '{
      8'h7E, 8'hDB, 8'h70, 8'h81,
      8'h0E, 8'h4F, 8'h84, 8'h4C, 8'h83, 8'hD6, 8'h7D, 8'hA2,
      8'h4F, 8'hDB, 8'hC4, 8'h1D, 8'h63, 8'h00, 8'h19, 8'h02,
      8'h1A, 8'h80, 8'h80, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'h04, 8'hFF, 8'hFF, 8'h89, 8'h7C
   };

   // Default image byte at an address below IMAGE_BYTES
   function automatic logic [7:0] image_byte(logic [8:0] a);
      logic [8:0] t;
      t = a - 9'(TAIL_START);
      if (a < 9'(HEAD_BYTES)) begin
         return IMAGE_HEAD[a[7:0]];
      end else if (a >= 9'(TAIL_START)) begin
         return IMAGE_TAIL[t[5:0]];
      end
      return ERASED_BYTE;
   endfunction

endpackage

// ===== rtl/spi_ee_mem.sv =====
module spi_ee_mem #(
   parameter int MEM_BYTES = spi_ee_pkg::MEM_BYTES_DEFAULT,
   localparam int ADDR_W = $clog2(MEM_BYTES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spi_ee_pkg::mem_req_type mem_req,
   input  logic [ADDR_W-1:0]       mem_addr,
   output logic [7:0]              rd_data,
   output logic                    fill_busy
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);

   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        rd_data_ff;
   logic              fill_busy_ff, fill_busy_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [7:0]        fill_byte;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // Advance the image sweep after reset
   always_comb begin
      fill_addr_in = fill_addr_ff;
      fill_busy_in = fill_busy_ff;
      if (fill_busy_ff) begin
         fill_addr_in = ADDR_W'(fill_addr_ff + 1'b1);
         if (fill_addr_ff == LAST_ADDR) begin
            fill_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_addr_ff <= '0;
      end else begin
         fill_busy_ff <= fill_busy_in;
         fill_addr_ff <= fill_addr_in;
      end
   end

   // Pick image byte or erased byte for the sweep
   always_comb begin
      if (32'(fill_addr_ff) < spi_ee_pkg::IMAGE_BYTES) begin
         fill_byte = spi_ee_pkg::image_byte(9'(fill_addr_ff));
      end else begin
         fill_byte = spi_ee_pkg::ERASED_BYTE;
      end
   end

   // Steer the write port between sweep and SPI machine
   assign wr_en   = fill_busy_ff | mem_req.wr_en;
   assign wr_addr = fill_busy_ff ? fill_addr_ff : mem_addr;
   assign wr_data = fill_busy_ff ? fill_byte : mem_req.wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill_busy = fill_busy_ff;

`ifndef NO_ASSERTIONS
   a_no_access_during_fill: assert property (@(posedge clock) disable iff (reset)
      fill_busy_ff |-> !(mem_req.rd_en || mem_req.wr_en))
      else $error("memory access issued during image sweep");
`endif

endmodule

// ===== rtl/spi_ee_ctrl.sv =====
module spi_ee_ctrl #(
   parameter int MEM_BYTES = spi_ee_pkg::MEM_BYTES_DEFAULT,
   localparam int ADDR_W = $clog2(MEM_BYTES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [1:0]               req_op,
   input  logic [7:0]               req_rx_byte,
   input  logic [11:0]              req_direct_addr,
   input  logic [7:0]               req_direct_data,
   output spi_ee_pkg::mem_req_type  mem_req,
   output logic [ADDR_W-1:0]        mem_addr,
   output spi_ee_pkg::rsp_push_type push
);

   localparam logic [ADDR_W:0]   MEM_TOP   = (ADDR_W+1)'(MEM_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);

   spi_ee_pkg::phase_type phase_ff, phase_in;
   spi_ee_pkg::pend_type  pend_ff, pend_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  sel_ff, sel_in;
   spi_ee_pkg::op_type    op;
   logic [ADDR_W-1:0]     lo_addr;
   logic [ADDR_W-1:0]     direct_addr;
   logic [ADDR_W-1:0]     hi_tab [256];

   // Byte offset times 256, reduced to the memory size, as a constant table
   for (genvar g = 0; g < 256; g++) begin : g_hi_tab
      localparam logic [ADDR_W-1:0] HI_VAL = ADDR_W'((g * 256) % MEM_BYTES);
      assign hi_tab[g] = HI_VAL;
   end

   // Fold a sum below twice the memory size back into range
   function automatic logic [ADDR_W-1:0] wrap_sum(logic [ADDR_W:0] s);
      return (s >= MEM_TOP) ? ADDR_W'(s - MEM_TOP) : ADDR_W'(s);
   endfunction

   function automatic logic [ADDR_W-1:0] next_addr(logic [ADDR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : ADDR_W'(a + 1'b1);
   endfunction

   assign op = spi_ee_pkg::op_type'(req_op);

   // Combine stored high part with the low address byte
   assign lo_addr = wrap_sum({1'b0, addr_ff} + (ADDR_W+1)'(req_rx_byte));
   assign direct_addr = wrap_sum({1'b0, hi_tab[{4'b0000, req_direct_addr[11:8]}]}
                                 + (ADDR_W+1)'(req_direct_addr[7:0]));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (op)
            spi_ee_pkg::OP_BYTE: begin
               if (sel_ff) begin
                  unique case (phase_ff)
                     spi_ee_pkg::PH_COMMAND: begin
                        if (req_rx_byte == spi_ee_pkg::CMD_READ ||
                            req_rx_byte == spi_ee_pkg::CMD_WRITE) begin
                           phase_in = spi_ee_pkg::PH_ADDR_HIGH;
                        end
                     end
                     spi_ee_pkg::PH_ADDR_HIGH: begin
                        phase_in = spi_ee_pkg::PH_ADDR_LOW;
                     end
                     spi_ee_pkg::PH_ADDR_LOW: begin
                        if (pend_ff == spi_ee_pkg::PEND_READ) begin
                           phase_in = spi_ee_pkg::PH_READ;
                        end else if (pend_ff == spi_ee_pkg::PEND_WRITE) begin
                           phase_in = spi_ee_pkg::PH_WRITE;
                        end else begin
                           phase_in = spi_ee_pkg::PH_COMMAND;
                        end
                     end
                     spi_ee_pkg::PH_READ, spi_ee_pkg::PH_WRITE: begin
                        phase_in = phase_ff;
                     end
                     default: begin
                        phase_in = spi_ee_pkg::PH_COMMAND;
                     end
                  endcase
               end
            end
            spi_ee_pkg::OP_SEL_ON, spi_ee_pkg::OP_SEL_OFF: begin
               phase_in = spi_ee_pkg::PH_COMMAND;
            end
            spi_ee_pkg::OP_DIRECT: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Address, command, select, memory access and result
   always_comb begin
      pend_in         = pend_ff;
      addr_in         = addr_ff;
      sel_in          = sel_ff;
      mem_req.rd_en   = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_data = req_rx_byte;
      mem_addr        = addr_ff;
      push.valid      = 1'b0;
      push.use_mem    = 1'b0;
      push.tx_byte    = spi_ee_pkg::RESP_ZERO;
      if (take) begin
         unique case (op)
            spi_ee_pkg::OP_BYTE: begin
               push.valid = 1'b1;
               if (!sel_ff) begin
                  push.tx_byte = spi_ee_pkg::RESP_IDLE;
               end else begin
                  unique case (phase_ff)
                     spi_ee_pkg::PH_COMMAND: begin
                        if (req_rx_byte == spi_ee_pkg::CMD_READ) begin
                           pend_in      = spi_ee_pkg::PEND_READ;
                           push.tx_byte = spi_ee_pkg::RESP_READ_CMD;
                        end else if (req_rx_byte == spi_ee_pkg::CMD_WRITE) begin
                           pend_in = spi_ee_pkg::PEND_WRITE;
                        end
                     end
                     spi_ee_pkg::PH_ADDR_HIGH: begin
                        addr_in      = hi_tab[req_rx_byte];
                        push.tx_byte = spi_ee_pkg::RESP_ADDR_HIGH;
                     end
                     spi_ee_pkg::PH_ADDR_LOW: begin
                        addr_in = lo_addr;
                        if (pend_ff == spi_ee_pkg::PEND_READ) begin
                           mem_req.rd_en = 1'b1;
                           mem_addr      = lo_addr;
                           push.use_mem  = 1'b1;
                           addr_in       = next_addr(lo_addr);
                        end
                     end
                     spi_ee_pkg::PH_READ: begin
                        mem_req.rd_en = 1'b1;
                        push.use_mem  = 1'b1;
                        addr_in       = next_addr(addr_ff);
                     end
                     spi_ee_pkg::PH_WRITE: begin
                        mem_req.wr_en = 1'b1;
                        addr_in       = next_addr(addr_ff);
                     end
                     default: begin
                        push.tx_byte = spi_ee_pkg::RESP_ZERO;
                     end
                  endcase
               end
            end
            spi_ee_pkg::OP_SEL_ON: begin
               sel_in     = 1'b1;
               pend_in    = spi_ee_pkg::PEND_NONE;
               addr_in    = '0;
               push.valid = 1'b1;
            end
            spi_ee_pkg::OP_SEL_OFF: begin
               sel_in  = 1'b0;
               pend_in = spi_ee_pkg::PEND_NONE;
               addr_in = '0;
            end
            spi_ee_pkg::OP_DIRECT: begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = req_direct_data;
               mem_addr        = direct_addr;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spi_ee_pkg::PH_COMMAND;
         pend_ff  <= spi_ee_pkg::PEND_NONE;
         addr_ff  <= '0;
         sel_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         addr_ff  <= addr_in;
         sel_ff   <= sel_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_open_needs_select: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != spi_ee_pkg::PH_COMMAND) |-> sel_ff)
      else $error("transfer phase open while deselected");
   a_phase_matches_command: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == spi_ee_pkg::PH_READ) |-> (pend_ff == spi_ee_pkg::PEND_READ)) and
      ((phase_ff == spi_ee_pkg::PH_WRITE) |-> (pend_ff == spi_ee_pkg::PEND_WRITE)))
      else $error("data phase disagrees with pending command");
   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= LAST_ADDR)
      else $error("current address beyond memory");
`endif

endmodule

// ===== rtl/spi_ee_out.sv =====
module spi_ee_out (
   input  logic                     clock,
   input  logic                     reset,
   input  spi_ee_pkg::rsp_push_type push,
   input  logic [7:0]               rd_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_tx_byte,
   output logic                     hold
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_use_mem_ff;
   logic [7:0] s1_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       s1_adv;

   // Move the memory stage on when the output slot frees up
   assign s1_adv = !out_valid_ff || rsp_ready;
   assign hold   = s1_valid_ff && !s1_adv;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      if (push.valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
         out_byte_in  = s1_use_mem_ff ? rd_data : s1_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payload; no reset needed
   always_ff @(posedge clock) begin
      if (push.valid) begin
         s1_use_mem_ff <= push.use_mem;
         s1_byte_ff    <= push.tx_byte;
      end
      out_byte_ff <= out_byte_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_tx_byte = out_byte_ff;

`ifndef NO_ASSERTIONS
   a_no_push_over_held: assert property (@(posedge clock) disable iff (reset)
      hold |-> !push.valid)
      else $error("request pushed over a held memory stage");
`endif

endmodule

// ===== rtl/spi_eeprom_slave_core.sv =====
// Channel   Direction  Ports                                            Handshake
// request   in         req_op, req_rx_byte, req_direct_addr,            req_valid/req_ready
//                      req_direct_data
// response  out        rsp_tx_byte                                      rsp_valid/rsp_ready
//
// One request per cycle while req_ready is high; SPI state lives in registers and each
// request makes at most one access to the byte memory, whose read port is registered.
// A response passes the memory read stage, then the output register.
// After reset an image sweep writes all MEM_BYTES bytes, one per cycle, with req_ready low.
// A held response stops requests only once the memory stage behind it is also full.
module spi_eeprom_slave_core #(
   parameter int MEM_BYTES = spi_ee_pkg::MEM_BYTES_DEFAULT,
   localparam int ADDR_W = $clog2(MEM_BYTES)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic [11:0] req_direct_addr,
   input  logic [7:0]  req_direct_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte
);

   spi_ee_pkg::mem_req_type  mem_req;
   spi_ee_pkg::rsp_push_type push;
   logic [ADDR_W-1:0]        mem_addr;
   logic [7:0]               rd_data;
   logic                     fill_busy;
   logic                     hold;
   logic                     take;

   // Accept when the sweep is done and the memory stage can move
   assign req_ready = !fill_busy && !hold;
   assign take      = req_valid && req_ready;

   spi_ee_ctrl #(
      .MEM_BYTES(MEM_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .req_op          (req_op),
      .req_rx_byte     (req_rx_byte),
      .req_direct_addr (req_direct_addr),
      .req_direct_data (req_direct_data),
      .mem_req         (mem_req),
      .mem_addr        (mem_addr),
      .push            (push)
   );

   spi_ee_mem #(
      .MEM_BYTES(MEM_BYTES)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .mem_addr  (mem_addr),
      .rd_data   (rd_data),
      .fill_busy (fill_busy)
   );

   spi_ee_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .rd_data     (rd_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_tx_byte (rsp_tx_byte),
      .hold        (hold)
   );

endmodule

// ===== tb/spi_eeprom_slave_checker.sv =====
`timescale 1ns / 1ps

module spi_eeprom_slave_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic [11:0] req_direct_addr,
   input  logic [7:0]  req_direct_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_tx_byte,
   output int          errors,
   output int          pending
);

   localparam int DEPTH = spi_ee_pkg::MEM_BYTES_DEFAULT;

   // Shadow of the slave: memory contents and SPI machine
   logic [7:0]            eeprom [DEPTH];
   spi_ee_pkg::phase_type phase;
   spi_ee_pkg::pend_type  pend;
   int unsigned           cur_addr;
   bit                    selected;

   // Transmit bytes still owed by the block, oldest first
   logic [7:0]  tx_due [$];

   // Return the machine to its command state
   task automatic restart_machine();
      phase    = spi_ee_pkg::PH_COMMAND;
      pend     = spi_ee_pkg::PEND_NONE;
      cur_addr = 0;
   endtask

   // Work out the transmit byte for one received byte and advance the machine
   task automatic take_rx(input logic [7:0] rx, output logic [7:0] tx);
      tx = spi_ee_pkg::RESP_ZERO;
      if (!selected) begin
         tx = spi_ee_pkg::RESP_IDLE;
      end else begin
         case (phase)
            spi_ee_pkg::PH_COMMAND: begin
               if (rx == spi_ee_pkg::CMD_READ) begin
                  pend  = spi_ee_pkg::PEND_READ;
                  phase = spi_ee_pkg::PH_ADDR_HIGH;
                  tx    = spi_ee_pkg::RESP_READ_CMD;
               end else if (rx == spi_ee_pkg::CMD_WRITE) begin
                  pend  = spi_ee_pkg::PEND_WRITE;
                  phase = spi_ee_pkg::PH_ADDR_HIGH;
               end
            end
            spi_ee_pkg::PH_ADDR_HIGH: begin
               cur_addr = {rx, 8'h00};
               phase    = spi_ee_pkg::PH_ADDR_LOW;
               tx       = spi_ee_pkg::RESP_ADDR_HIGH;
            end
            spi_ee_pkg::PH_ADDR_LOW: begin
               cur_addr = (cur_addr | rx) % DEPTH;
               if (pend == spi_ee_pkg::PEND_READ) begin
                  tx       = eeprom[cur_addr];
                  cur_addr = (cur_addr + 1) % DEPTH;
                  phase    = spi_ee_pkg::PH_READ;
               end else if (pend == spi_ee_pkg::PEND_WRITE) begin
                  phase = spi_ee_pkg::PH_WRITE;
               end else begin
                  phase = spi_ee_pkg::PH_COMMAND;
               end
            end
            spi_ee_pkg::PH_READ: begin
               tx       = eeprom[cur_addr];
               cur_addr = (cur_addr + 1) % DEPTH;
            end
            spi_ee_pkg::PH_WRITE: begin
               eeprom[cur_addr] = rx;
               cur_addr         = (cur_addr + 1) % DEPTH;
            end
            default: begin
               phase = spi_ee_pkg::PH_COMMAND;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      logic [7:0] tx;
      logic [7:0] want;
      int         i;
      if (reset) begin
         // Load the default image over an erased array
         for (i = 0; i < DEPTH; i++) begin
            eeprom[i] = spi_ee_pkg::ERASED_BYTE;
         end
         for (i = 0; i < spi_ee_pkg::HEAD_BYTES; i++) begin
            if (i < DEPTH) begin
               eeprom[i] = spi_ee_pkg::IMAGE_HEAD[i];
            end
         end
         for (i = 0; i < spi_ee_pkg::TAIL_BYTES; i++) begin
            if (spi_ee_pkg::TAIL_START + i < DEPTH) begin
               eeprom[spi_ee_pkg::TAIL_START + i] = spi_ee_pkg::IMAGE_TAIL[i];
            end
         end
         restart_machine();
         selected = 1'b0;
         tx_due.delete();
         errors = 0;
      end else begin
         // Compare an accepted response with the oldest owed byte
         if (rsp_valid && rsp_ready) begin
            if (tx_due.size() == 0) begin
               errors++;
               $display("%0t: tx_byte expected none, got %02h", $time, rsp_tx_byte);
            end else begin
               want = tx_due.pop_front();
               if (rsp_tx_byte !== want) begin
                  errors++;
                  $display("%0t: tx_byte expected %02h, got %02h", $time, want,
                           rsp_tx_byte);
               end
            end
         end
         // Predict the effect of an accepted request
         if (req_valid && req_ready) begin
            case (spi_ee_pkg::op_type'(req_op))
               spi_ee_pkg::OP_BYTE: begin
                  take_rx(req_rx_byte, tx);
                  tx_due.push_back(tx);
               end
               spi_ee_pkg::OP_SEL_ON: begin
                  selected = 1'b1;
                  restart_machine();
                  tx_due.push_back(spi_ee_pkg::RESP_ZERO);
               end
               spi_ee_pkg::OP_SEL_OFF: begin
                  selected = 1'b0;
                  restart_machine();
               end
               default: begin
                  eeprom[req_direct_addr % DEPTH] = req_direct_data;
               end
            endcase
         end
      end
      pending = tx_due.size();
   end

endmodule

// ===== tb/spi_eeprom_slave_core_test.sv =====
`timescale 1ns / 1ps

module spi_eeprom_slave_core_test;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op          = spi_ee_pkg::OP_BYTE;
   logic [7:0]  req_rx_byte     = 8'h00;
   logic [11:0] req_direct_addr = 12'h000;
   logic [7:0]  req_direct_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_tx_byte;

   int errors;
   int pending;
   int sent           = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   always #1 clock = ~clock;

   spi_eeprom_slave_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_rx_byte     (req_rx_byte),
      .req_direct_addr (req_direct_addr),
      .req_direct_data (req_direct_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte)
   );

   spi_eeprom_slave_checker eeprom_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_rx_byte     (req_rx_byte),
      .req_direct_addr (req_direct_addr),
      .req_direct_data (req_direct_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte),
      .errors          (errors),
      .pending         (pending)
   );

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Present one request, idling first at random, and hold it until taken
   task automatic send(input spi_ee_pkg::op_type op, input logic [7:0] rx,
                       input logic [11:0] daddr, input logic [7:0] ddata);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_rx_byte     <= rx;
      req_direct_addr <= daddr;
      req_direct_data <= ddata;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent++;
      @(negedge clock);
   endtask

   task automatic spi_byte(input logic [7:0] rx);
      send(spi_ee_pkg::OP_BYTE, rx, 12'($urandom), 8'($urandom));
   endtask

   task automatic select_on();
      send(spi_ee_pkg::OP_SEL_ON, 8'($urandom), 12'($urandom), 8'($urandom));
   endtask

   task automatic select_off();
      send(spi_ee_pkg::OP_SEL_OFF, 8'($urandom), 12'($urandom), 8'($urandom));
   endtask

   task automatic direct_write(input logic [11:0] daddr, input logic [7:0] ddata);
      send(spi_ee_pkg::OP_DIRECT, 8'($urandom), daddr, ddata);
   endtask

   // Hold off new requests until every owed byte has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   // One random transfer: mostly well-formed, sometimes a single noise request
   task automatic random_transfer();
      int         pick;
      int         n;
      logic [7:0] cmd;
      logic [7:0] hi;
      logic [7:0] lo;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send(spi_ee_pkg::op_type'(2'($urandom_range(3))), 8'($urandom), 12'($urandom),
              8'($urandom));
      end else begin
         select_on();
         pick = $urandom_range(99);
         if (pick < 45) begin
            cmd = spi_ee_pkg::CMD_READ;
         end else if (pick < 85) begin
            cmd = spi_ee_pkg::CMD_WRITE;
         end else begin
            cmd = 8'($urandom);
         end
         spi_byte(cmd);
         if ($urandom_range(9) == 0) begin
            direct_write(12'($urandom), 8'($urandom));
         end
         // Aim at the end of memory, a small shared window, or anywhere
         pick = $urandom_range(3);
         if (pick == 0) begin
            hi = {4'($urandom), 4'hF};
            lo = 8'($urandom_range(248, 255));
         end else if (pick == 1) begin
            hi = {4'($urandom), 4'h0};
            lo = 8'($urandom_range(0, 31));
         end else begin
            hi = 8'($urandom);
            lo = 8'($urandom);
         end
         spi_byte(hi);
         spi_byte(lo);
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(15) == 0) begin
               direct_write(12'($urandom), 8'($urandom));
            end
            spi_byte(8'($urandom));
         end
         if ($urandom_range(9) != 0) begin
            select_off();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: deselected bytes, wrap at the end, unknown commands,
      // direct write inside an open read
      spi_byte(8'h00);
      spi_byte(8'hFF);
      select_on();
      spi_byte(spi_ee_pkg::CMD_READ);
      spi_byte(8'hFF);
      spi_byte(8'hFF);
      spi_byte(8'h00);
      spi_byte(8'hFF);
      select_off();
      select_on();
      spi_byte(spi_ee_pkg::CMD_WRITE);
      spi_byte(8'h0F);
      spi_byte(8'hFE);
      spi_byte(8'hAA);
      spi_byte(8'h55);
      spi_byte(8'h12);
      select_on();
      spi_byte(8'h00);
      spi_byte(8'hFF);
      spi_byte(spi_ee_pkg::CMD_READ);
      direct_write(12'hFFF, 8'h00);
      spi_byte(8'h0F);
      spi_byte(8'hFE);
      spi_byte(8'h00);
      spi_byte(8'hFF);
      direct_write(12'h000, 8'hFF);
      select_off();
      drain();

      // Random transfers under four idle and stall mixes
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         while (sent < 26 + 100 * (mix + 1)) begin
            random_transfer();
         end
         drain();
      end

      // Let the pipeline settle after the last byte
      repeat (8) @(negedge clock);
      $display("Sent %0d requests: directed edge cases, then random read and write", sent);
      $display("transfers with noise under four idle and stall mixes; %0d failures.", errors);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

endmodule
